/* hw/rtl/rpf_pkg.sv */
`default_nettype none
package rpf_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 255;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] SYNC_A = 8'h48;
    localparam logic [7:0] SYNC_B = 8'h65;
    localparam logic [7:0] DIRECTION = 8'h20;
    localparam logic [7:0] CMD_RESET = 8'h03;

    typedef struct packed {
        logic       start;
        logic       last;
        logic [7:0] data;
        logic [7:0] cmd;
        logic [7:0] size;
        logic [7:0] hsum_lo;
        logic [7:0] hsum_hi;
        logic [7:0] psum_lo;
        logic [7:0] psum_hi;
    } t_entry;

    function automatic logic [15:0] hdr_sum(input logic [7:0] cmd, input logic [7:0] size);
        logic [7:0] b [6];
        logic [7:0] lo;
        logic [7:0] hi;
        b[0] = SYNC_A;
        b[1] = SYNC_B;
        b[2] = DIRECTION;
        b[3] = cmd;
        b[4] = 8'h00;
        b[5] = size;
        lo = 8'h00;
        hi = 8'h00;
        for (int k = 0; k < 6; k++) begin
            lo = lo + b[k];
            hi = hi + lo;
        end
        return {hi, lo};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rpf_in_if.sv */
`default_nettype none
interface rpf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink (input valid, input data_byte, input bytes_left, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rpf_out_if.sv */
`default_nettype none
interface rpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output out_byte, output frame_end, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input frame_end, input run_last,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/radio_packet_framer_unit.sv */
// Each input byte is written into the queue, and the output stage registers every output byte
// from the queue head: at most one output transfer per cycle, while the receiver is ready. An item
// inside a frame gives one output byte, a frame start item nine and a frame end item two more.
// A four-entry queue between the input classifier and the output sequencer absorbs bursts.
// Reset is synchronous and active low; it clears frame state, the queue and the output,
// and sets the command code to 3.
`default_nettype none
module radio_packet_framer_unit #(
    parameter int unsigned MAX_FRAME_BYTES = rpf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    rpf_in_if.sink          i_in,
    rpf_out_if.source       o_out
);
    import rpf_pkg::*;

    logic [7:0] r_cmd;
    logic       push, full, q_valid, pop;
    t_entry     push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_RESET;
        end else if (i_cfg_we) begin
            r_cmd <= i_cfg_data;
        end
    end

    rpf_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (r_cmd),
        .i_q_full (full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    rpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    rpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> o_out.run_last)
        else $error("frame end byte is not the last result of its item");

endmodule
`default_nettype wire

/* hw/rtl/rpf_front.sv */
`default_nettype none
module rpf_front #(
    parameter int unsigned MAX_FRAME_BYTES = rpf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rpf_in_if.sink             i_in,
    input  wire logic [7:0]    i_cmd,
    input  wire logic          i_q_full,
    output logic               o_push,
    output rpf_pkg::t_entry    o_entry
);
    import rpf_pkg::*;

    localparam logic [15:0] MAX16 = 16'(MAX_FRAME_BYTES);
    localparam logic [7:0]  MAX8 = 8'(MAX_FRAME_BYTES);

    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_sum_lo, n_sum_lo;
    logic [7:0]  r_sum_hi, n_sum_hi;

    logic        start;
    logic [7:0]  size;
    logic [7:0]  rem_after;
    logic [7:0]  lo_new;
    logic [7:0]  hi_new;
    logic [15:0] hsum;

    assign i_in.ready = !i_q_full;
    assign o_push = i_in.valid && !i_q_full;
    assign start = !r_in_frame;

    always_comb begin
        if (i_in.bytes_left == 16'd0) begin
            size = 8'd1;
        end else if (i_in.bytes_left > MAX16) begin
            size = MAX8;
        end else begin
            size = i_in.bytes_left[7:0];
        end
        rem_after = (start ? size : r_remaining) - 8'd1;
        lo_new = (start ? 8'h00 : r_sum_lo) + i_in.data_byte;
        hi_new = (start ? 8'h00 : r_sum_hi) + lo_new;
        hsum = hdr_sum(i_cmd, size);

        o_entry.start = start;
        o_entry.last = (rem_after == 8'd0);
        o_entry.data = i_in.data_byte;
        o_entry.cmd = i_cmd;
        o_entry.size = size;
        o_entry.hsum_lo = hsum[7:0];
        o_entry.hsum_hi = hsum[15:8];
        o_entry.psum_lo = lo_new;
        o_entry.psum_hi = hi_new;

        n_in_frame = r_in_frame;
        n_remaining = r_remaining;
        n_sum_lo = r_sum_lo;
        n_sum_hi = r_sum_hi;
        if (o_push) begin
            if (rem_after == 8'd0) begin
                n_in_frame = 1'b0;
                n_remaining = 8'd0;
                n_sum_lo = 8'h00;
                n_sum_hi = 8'h00;
            end else begin
                n_in_frame = 1'b1;
                n_remaining = rem_after;
                n_sum_lo = lo_new;
                n_sum_hi = hi_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_remaining <= 8'd0;
            r_sum_lo <= 8'h00;
            r_sum_hi <= 8'h00;
        end else begin
            r_in_frame <= n_in_frame;
            r_remaining <= n_remaining;
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rpf_queue.sv */
`default_nettype none
module rpf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rpf_pkg::t_entry  i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output rpf_pkg::t_entry       o_entry,
    input  wire logic             i_pop
);
    import rpf_pkg::*;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;
    logic                do_push, do_pop;

    assign o_full = (r_count == DEPTH_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rpf_back.sv */
`default_nettype none
module rpf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire rpf_pkg::t_entry  i_q_entry,
    output logic                  o_pop,
    rpf_out_if.source             o_out
);
    import rpf_pkg::*;

    localparam logic [3:0] PH_SYNC_A  = 4'd0;
    localparam logic [3:0] PH_SYNC_B  = 4'd1;
    localparam logic [3:0] PH_DIR     = 4'd2;
    localparam logic [3:0] PH_CMD     = 4'd3;
    localparam logic [3:0] PH_SIZE_HI = 4'd4;
    localparam logic [3:0] PH_SIZE_LO = 4'd5;
    localparam logic [3:0] PH_HSUM_LO = 4'd6;
    localparam logic [3:0] PH_HSUM_HI = 4'd7;
    localparam logic [3:0] PH_DATA    = 4'd8;
    localparam logic [3:0] PH_PSUM_LO = 4'd9;
    localparam logic [3:0] PH_PSUM_HI = 4'd10;

    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_fe;
    logic       r_rl;
    logic       r_mid;
    logic [3:0] r_phase;

    logic       adv, go, done;
    logic [3:0] phase;
    logic [7:0] n_byte;

    assign adv = !r_ov || o_out.ready;
    assign go = adv && i_q_valid;
    assign o_pop = go && done;

    always_comb begin
        if (r_mid) begin
            phase = r_phase;
        end else begin
            phase = i_q_entry.start ? PH_SYNC_A : PH_DATA;
        end
        done = ((phase == PH_DATA) && !i_q_entry.last) || (phase == PH_PSUM_HI);
        case (phase)
            PH_SYNC_A:  n_byte = SYNC_A;
            PH_SYNC_B:  n_byte = SYNC_B;
            PH_DIR:     n_byte = DIRECTION;
            PH_CMD:     n_byte = i_q_entry.cmd;
            PH_SIZE_HI: n_byte = 8'h00;
            PH_SIZE_LO: n_byte = i_q_entry.size;
            PH_HSUM_LO: n_byte = i_q_entry.hsum_lo;
            PH_HSUM_HI: n_byte = i_q_entry.hsum_hi;
            PH_DATA:    n_byte = i_q_entry.data;
            PH_PSUM_LO: n_byte = i_q_entry.psum_lo;
            PH_PSUM_HI: n_byte = i_q_entry.psum_hi;
            default:    n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_mid <= 1'b0;
            r_phase <= PH_SYNC_A;
        end else begin
            if (adv) begin
                r_ov <= i_q_valid;
            end
            if (go) begin
                r_mid <= !done;
                r_phase <= phase + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_byte <= n_byte;
            r_fe <= (phase == PH_PSUM_HI);
            r_rl <= done;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.out_byte = r_byte;
    assign o_out.frame_end = r_fe;
    assign o_out.run_last = r_rl;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
    import rpf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 16;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       run_last;
    } framed_byte_t;

    typedef enum logic [1:0] {RX_STEADY, RX_PATTERN, RX_COIN} rx_mode_e;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    rpf_in_if  in_ch ();
    rpf_out_if out_ch ();

    radio_packet_framer_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    framed_byte_t due_bytes [$];

    logic       open_frame;
    logic [7:0] bytes_due;
    logic [7:0] pay_lo;
    logic [7:0] pay_hi;
    logic [7:0] cmd_byte;

    int mismatches;
    int items_sent;
    int bytes_checked;
    int frames_seen;
    int cmd_writes;
    int idle_cycles;
    int burst_left;

    rx_mode_e    rx_mode;
    logic [15:0] rx_mask;
    logic [3:0]  rx_phase;
    bit          holdoff_req;
    bit          tx_gaps;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    function automatic void add_due(input logic [7:0] value, input logic frame_end);
        framed_byte_t entry;
        entry.value = value;
        entry.frame_end = frame_end;
        entry.run_last = 1'b0;
        due_bytes.push_back(entry);
    endfunction

    // Expected output bytes for one accepted payload byte.
    function automatic void predict_frame_bytes(input logic [7:0] d, input logic [15:0] left);
        logic [15:0]  sz;
        logic [7:0]   hdr [6];
        logic [7:0]   lo;
        logic [7:0]   hi;
        framed_byte_t tail;
        if (!open_frame) begin
            sz = (left == 16'd0) ? 16'd1 : left;
            if (sz > MAX_FRAME_BYTES_DEF) begin
                sz = 16'(MAX_FRAME_BYTES_DEF);
            end
            hdr = '{SYNC_A, SYNC_B, DIRECTION, cmd_byte, sz[15:8], sz[7:0]};
            lo = 8'h00;
            hi = 8'h00;
            for (int k = 0; k < 6; k++) begin
                lo = lo + hdr[k];
                hi = hi + lo;
                add_due(hdr[k], 1'b0);
            end
            add_due(lo, 1'b0);
            add_due(hi, 1'b0);
            open_frame = 1'b1;
            bytes_due = sz[7:0];
            pay_lo = 8'h00;
            pay_hi = 8'h00;
        end
        add_due(d, 1'b0);
        pay_lo = pay_lo + d;
        pay_hi = pay_hi + pay_lo;
        bytes_due = bytes_due - 8'd1;
        if (bytes_due == 8'd0) begin
            add_due(pay_lo, 1'b0);
            add_due(pay_hi, 1'b1);
            open_frame = 1'b0;
            pay_lo = 8'h00;
            pay_hi = 8'h00;
        end
        tail = due_bytes.pop_back();
        tail.run_last = 1'b1;
        due_bytes.push_back(tail);
    endfunction

    always @(posedge i_clk) begin : check_output
        framed_byte_t got;
        framed_byte_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.out_byte, out_ch.frame_end, out_ch.run_last};
            bytes_checked++;
            if (got.frame_end === 1'b1) begin
                frames_seen++;
            end
            if (due_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected output byte %02h end %0b last %0b",
                                        got.value, got.frame_end, got.run_last));
            end else begin
                want = due_bytes.pop_front();
                if (got.value !== want.value || got.frame_end !== want.frame_end
                        || got.run_last !== want.run_last) begin
                    note_mismatch($sformatf(
                        {"output %0d: expected byte %02h end %0b last %0b, ",
                         "got %02h end %0b last %0b"},
                        bytes_checked, want.value, want.frame_end, want.run_last,
                        got.value, got.frame_end, got.run_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d bytes still due.",
                     IDLE_LIMIT, due_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : receiver
        out_ch.ready = 1'b0;
        rx_phase = 4'd0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holdoff_req = 1'b0;
            end
            case (rx_mode)
                RX_STEADY: begin
                    out_ch.ready = 1'b1;
                end
                RX_PATTERN: begin
                    out_ch.ready = rx_mask[rx_phase];
                end
                default: begin
                    out_ch.ready = ($urandom_range(0, 3) != 0);
                end
            endcase
            rx_phase = rx_phase + 4'd1;
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic [15:0] left);
        int gap;
        if (tx_gaps && burst_left <= 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid = 1'b1;
        in_ch.data_byte = d;
        in_ch.bytes_left = left;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_frame_bytes(d, left);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), 16'(len - i));
        end
    endtask

    task automatic close_open_frame();
        while (open_frame) begin
            send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic settle_idle();
        in_ch.valid = 1'b0;
        while (due_bytes.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_command(input logic [7:0] code);
        settle_idle();
        i_cfg_we = 1'b1;
        i_cfg_data = code;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cmd_byte = code;
        cmd_writes++;
    endtask

    task automatic test_directed();
        rx_mode = RX_STEADY;
        tx_gaps = 1'b0;
        send_byte(8'h00, 16'd1);
        // A zero count at a frame start gives a one-byte frame.
        send_byte(8'hFF, 16'd0);
        send_byte(8'hA5, 16'd3);
        send_byte(8'h5A, 16'd2);
        send_byte(8'hFF, 16'd1);
        // The count is ignored once a frame is open.
        send_byte(8'h01, 16'd4);
        send_byte(8'h80, 16'hFFFF);
        send_byte(8'h7F, 16'd0);
        send_byte(8'hFE, 16'h8000);
        send_byte(8'h00, 16'd0);
        send_byte(8'hFF, 16'd1);
    endtask

    task automatic test_command_codes();
        rx_mode = RX_PATTERN;
        rx_mask = 16'hB6D5;
        tx_gaps = 1'b1;
        write_command(8'h00);
        send_message(2);
        write_command(8'hFF);
        send_message(1);
        write_command(8'h80);
        send_message(3);
        write_command(8'($urandom_range(0, 255)));
        send_message(2);
    endtask

    task automatic test_backpressure();
        rx_mode = RX_STEADY;
        tx_gaps = 1'b0;
        holdoff_req = 1'b1;
        send_message(12);
        send_message(3);
    endtask

    task automatic test_full_frame();
        write_command(8'($urandom_range(0, 255)));
        rx_mode = RX_COIN;
        tx_gaps = 1'b1;
        for (int i = 0; i < MAX_FRAME_BYTES_DEF; i++) begin
            send_byte(8'($urandom_range(0, 255)), 16'(65535 - i));
        end
    endtask

    task automatic test_random_traffic();
        int len;
        int start_items;
        logic [15:0] count;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                close_open_frame();
                write_command(8'($urandom_range(0, 255)));
            end
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            rx_mask = 16'($urandom) | 16'h0001;
            tx_gaps = ($urandom_range(0, 2) != 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if ($urandom_range(0, 4) != 0) begin
                send_message(len);
            end else begin
                send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 2 * len)));
                for (int i = 1; i < len; i++) begin
                    count = open_frame ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 8));
                    send_byte(8'($urandom_range(0, 255)), count);
                end
            end
        end
        close_open_frame();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 8'h00;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.bytes_left = 16'h0000;
        open_frame = 1'b0;
        bytes_due = 8'h00;
        pay_lo = 8'h00;
        pay_hi = 8'h00;
        cmd_byte = CMD_RESET;
        mismatches = 0;
        items_sent = 0;
        bytes_checked = 0;
        frames_seen = 0;
        cmd_writes = 0;
        idle_cycles = 0;
        burst_left = 0;
        rx_mode = RX_STEADY;
        rx_mask = 16'hFFFF;
        holdoff_req = 1'b0;
        tx_gaps = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_command_codes();
        test_backpressure();
        test_full_frame();
        test_random_traffic();

        in_ch.valid = 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d payload bytes and checked %0d framed bytes over %0d frames.",
                 items_sent, bytes_checked, frames_seen);
        $display("Command code rewritten %0d times; %0d mismatches seen.",
                 cmd_writes, mismatches);
        if (mismatches == 0 && due_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* radio_packet_framer_unit.f */
hw/rtl/rpf_pkg.sv
hw/rtl/rpf_in_if.sv
hw/rtl/rpf_out_if.sv
hw/rtl/rpf_front.sv
hw/rtl/rpf_queue.sv
hw/rtl/rpf_back.sv
hw/rtl/radio_packet_framer_unit.sv
sim/tb.sv
